FILE: hw/rtl/lif_spiking_gate_classifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spiking gate classifier
// Concurrent checks that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef LIF_SPIKING_GATE_CLASSIFIER_ASSERT_SVH
`define LIF_SPIKING_GATE_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define LSGC_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define LSGC_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define LSGC_ASSERT_IMPL(label, clk, rst, a, c)
`define LSGC_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

FILE: hw/rtl/lsgc_pkg.sv
// ----------------------------------------------------------------------------
// lsgc_pkg
// Constants, tables and helpers shared by the classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none
package lsgc_pkg;
  localparam int NUM_STEPS    = 25;
  localparam int HIDDEN_COUNT = 12;
  localparam int MAX_FEATURES = 5;
  localparam int ROM_ROWS     = 12;
  localparam int HID_W        = $clog2(HIDDEN_COUNT);
  localparam int STEP_W       = $clog2(NUM_STEPS + 1);

  localparam logic [2:0] ADDR_A_LEAK = 3'd0;
  localparam logic [2:0] ADDR_A_THR  = 3'd1;
  localparam logic [2:0] ADDR_B_LEAK = 3'd2;
  localparam logic [2:0] ADDR_B_THR  = 3'd3;

  localparam logic signed [15:0] BIAS1_A = -16'sd1638;
  localparam logic signed [15:0] BIAS1_B = -16'sd2048;
  localparam logic signed [15:0] W2_A    = 16'sd2458;
  localparam logic signed [15:0] W2_B    = 16'sd2253;
  localparam logic signed [15:0] BIAS2_A = -16'sd819;
  localparam logic signed [15:0] BIAS2_B = -16'sd1024;
  localparam logic signed [20:0] MEM_MAX = 21'sd1048575;
  localparam logic signed [20:0] MEM_MIN = -21'sd1048576;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  typedef struct packed {
    logic                    start;
    logic                    gate_b;
    logic [15:0]             leak;
    logic [15:0]             thr;
  } lane_ctl_t;

  function automatic logic [12:0] wrom(input logic gb, input logic [3:0] r,
                                       input logic [2:0] i);
    logic [12:0] ta [12][4];
    logic [12:0] tb [12][5];
    ta = '{'{13'd3277,13'd4096,13'd5734,13'd7373},'{13'd3621,13'd3908,13'd6479,13'd6213},
           '{13'd3649,13'd3516,13'd5114,13'd6018},'{13'd3335,13'd3281,13'd5505,13'd7340},
           '{13'd2967,13'd3419,13'd6545,13'd6434},'{13'd2884,13'd3803,13'd5289,13'd5866},
           '{13'd3163,13'd4080,13'd5295,13'd7245},'{13'd3546,13'd3995,13'd6546,13'd6665},
           '{13'd3682,13'd3627,13'd5498,13'd5769},'{13'd3446,13'd3313,13'd5119,13'd7095},
           '{13'd3054,13'd3343,13'd6482,13'd6888},'{13'd2867,13'd3688,13'd5727,13'd5734}};
    tb = '{'{13'd5325,13'd6349,13'd3277,13'd4096,13'd4915},
           '{13'd5842,13'd6066,13'd3621,13'd3908,13'd5474},
           '{13'd5883,13'd5479,13'd3649,13'd3516,13'd4450},
           '{13'd5412,13'd5126,13'd3335,13'd3281,13'd4744},
           '{13'd4860,13'd5333,13'd2967,13'd3419,13'd5523},
           '{13'd4736,13'd5908,13'd2884,13'd3803,13'd4581},
           '{13'd5153,13'd6324,13'd3163,13'd4080,13'd4585},
           '{13'd5728,13'd6198,13'd3546,13'd3995,13'd5524},
           '{13'd5933,13'd5645,13'd3682,13'd3627,13'd4738},
           '{13'd5578,13'd5174,13'd3446,13'd3313,13'd4454},
           '{13'd4991,13'd5219,13'd3054,13'd3343,13'd5476},
           '{13'd4710,13'd5737,13'd2867,13'd3688,13'd4910}};
    if (gb) begin
      return (i < 3'd5) ? tb[r][i] : 13'd0;
    end
    return (i < 3'd4) ? ta[r][i[1:0]] : 13'd0;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/lsgc_norm.sv
// ----------------------------------------------------------------------------
// lsgc_norm
// Clamps one feature, divides by its scale and saturates at 3.0 (Q2.12).
// ----------------------------------------------------------------------------
`default_nettype none
module lsgc_norm import lsgc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              gate_b,
  input  wire logic [2:0]        idx,
  input  wire logic signed [23:0] feat,
  output logic [13:0]            norm
);
  logic [26:0] v16;
  logic [31:0] recip;
  logic [58:0] prod;
  logic [26:0] q;
  // ceil(2^32 / scale) gives the exact quotient below the saturation point
  always_comb begin
    v16 = feat[23] ? 27'd0 : {feat[22:0], 4'd0};
    case ({gate_b, idx})
      4'b0_000: recip = 32'd42949673;
      4'b0_001: recip = 32'd71582789;
      4'b0_010: recip = 32'd143165577;
      4'b0_011: recip = 32'd107374183;
      4'b1_000: recip = 32'd858993460;
      4'b1_001: recip = 32'd1431655766;
      4'b1_010: recip = 32'd429496730;
      4'b1_011: recip = 32'd1073741824;
      4'b1_100: recip = 32'd8589935;
      default:  recip = 32'd0;
    endcase
    prod = 59'(v16) * 59'(recip);
    q = prod[58:32];
  end
  always_ff @(posedge clk) begin
    norm <= (q > 27'd12288) ? 14'd12288 : q[13:0];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/lsgc_lane.sv
// ----------------------------------------------------------------------------
// lsgc_lane
// One hidden neuron: forms its current, then steps its membrane once per tick.
// ----------------------------------------------------------------------------
`default_nettype none
module lsgc_lane import lsgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lane_ctl_t   ctl,
  input  wire logic [3:0]  row,
  input  wire logic [13:0] norm [MAX_FEATURES],
  input  wire logic        tick,
  output logic             spike
);
  logic signed [15:0] cur;
  logic signed [20:0] mem;
  logic signed [35:0] acc;
  logic signed [37:0] mprod;
  logic signed [21:0] sum;
  logic signed [20:0] mnew;
  always_comb begin
    acc = 36'(ctl.gate_b ? BIAS1_B : BIAS1_A) * 36'sd4096;
    for (int i = 0; i < MAX_FEATURES; i++) begin
      acc = acc + $signed({10'd0, wrom(ctl.gate_b, row, 3'(i))})
                  * $signed({22'd0, norm[i]});
    end
    mprod = mem * $signed({1'b0, ctl.leak});
    sum = 22'(mprod >>> 16) + 22'(cur);
    if (sum > 22'(MEM_MAX)) mnew = MEM_MAX;
    else if (sum < 22'(MEM_MIN)) mnew = MEM_MIN;
    else mnew = sum[20:0];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      spike <= 1'b0;
    end else if (ctl.start) begin
      spike <= 1'b0;
    end else if (tick) begin
      spike <= (mnew >= $signed({5'd0, ctl.thr}));
    end
    if (ctl.start) begin
      mem <= '0;
      if ((acc >>> 12) > 36'sd32767) cur <= 16'sd32767;
      else if ((acc >>> 12) < -36'sd32768) cur <= -16'sd32768;
      else cur <= 16'(acc >>> 12);
    end else if (tick) begin
      mem <= (mnew >= $signed({5'd0, ctl.thr})) ? mnew - $signed({5'd0, ctl.thr}) : mnew;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/lsgc_merge.sv
// ----------------------------------------------------------------------------
// lsgc_merge
// Counts lane spikes into the output neuron and tracks fire and peak.
// ----------------------------------------------------------------------------
`default_nettype none
module lsgc_merge import lsgc_pkg::*; (
  input  wire logic                   clk,
  input  wire lane_ctl_t              ctl,
  input  wire logic [HIDDEN_COUNT-1:0] spikes,
  input  wire logic                   tick,
  output logic                        fired,
  output logic [19:0]                 peak
);
  logic signed [20:0] mem;
  logic signed [21:0] c2;
  logic signed [15:0] cur;
  logic signed [37:0] mprod;
  logic signed [21:0] sum;
  logic signed [20:0] mnew;
  always_comb begin
    c2 = 22'(ctl.gate_b ? BIAS2_B : BIAS2_A)
         + 22'($countones(spikes)) * 22'(ctl.gate_b ? W2_B : W2_A);
    cur = (c2 > 22'sd32767) ? 16'sd32767 : 16'(c2);
    mprod = mem * $signed({1'b0, ctl.leak});
    sum = 22'(mprod >>> 16) + 22'(cur);
    if (sum > 22'(MEM_MAX)) mnew = MEM_MAX;
    else if (sum < 22'(MEM_MIN)) mnew = MEM_MIN;
    else mnew = sum[20:0];
  end
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mem <= '0; fired <= 1'b0; peak <= '0;
    end else if (tick) begin
      if (mnew > $signed({1'b0, peak})) peak <= mnew[19:0];
      if (mnew >= $signed({5'd0, ctl.thr})) begin
        fired <= 1'b1;
        mem <= mnew - $signed({5'd0, ctl.thr});
      end else begin
        mem <= mnew;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/lif_spiking_gate_classifier.sv
// ----------------------------------------------------------------------------
// lif_spiking_gate_classifier
// Twelve parallel hidden LIF lanes feeding one output neuron.
// One item at a time: a new item is accepted only after the result is taken.
// Hidden lane i runs step t at tick t; the output neuron steps in the cycle after.
// Reset: synchronous; control, config and lane spike registers reset, block idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lif_spiking_gate_classifier_assert.svh"
module lif_spiking_gate_classifier import lsgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: feature_zero..feature_four, 24 bits each from bit 0
  input  wire logic [119:0] s_tdata,
  // tuser: req_type
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: fired, peak_potential, dominant_index, dominant_value from bit 0; 48 bits
  output logic [47:0]      m_tdata
);
  logic [15:0] a_leak, a_thr, b_leak, b_thr;
  state_t state, state_next;
  logic [STEP_W:0] cnt;
  logic gb;
  logic signed [23:0] feat [MAX_FEATURES];
  logic [13:0] norm [MAX_FEATURES];
  logic [13:0] nmask [MAX_FEATURES];
  lane_ctl_t ctl;
  logic [HIDDEN_COUNT-1:0] spikes;
  logic tick, mtick, fired;
  logic [19:0] peak;
  logic [2:0] dom;
  logic [2:0] dom_next;
  logic [13:0] best;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      a_leak <= 16'd58982; a_thr <= 16'd4096; b_leak <= 16'd58982; b_thr <= 16'd4096;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ADDR_A_LEAK[1:0]: a_leak <= pwdata[15:0];
        ADDR_A_THR[1:0]:  a_thr  <= pwdata[15:0];
        ADDR_B_LEAK[1:0]: b_leak <= pwdata[15:0];
        ADDR_B_THR[1:0]:  b_thr  <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      ADDR_A_LEAK[1:0]: prdata = {16'd0, a_leak};
      ADDR_A_THR[1:0]:  prdata = {16'd0, a_thr};
      ADDR_B_LEAK[1:0]: prdata = {16'd0, b_leak};
      default:          prdata = {16'd0, b_thr};
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      gb <= s_tuser;
      for (int i = 0; i < MAX_FEATURES; i++) feat[i] <= s_tdata[24*i +: 24];
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_FEATURES; g++) begin : g_norm
      lsgc_norm u_norm (.clk(clk), .gate_b(gb), .idx(3'(g)), .feat(feat[g]),
                        .norm(norm[g]));
      assign nmask[g] = (!gb && g == 4) ? 14'd0 : norm[g];
    end
    for (g = 0; g < HIDDEN_COUNT; g++) begin : g_lane
      lsgc_lane u_lane (.clk(clk), .rst(rst), .ctl(ctl), .row(4'(g % ROM_ROWS)),
                        .norm(nmask), .tick(tick), .spike(spikes[g]));
    end
  endgenerate

  lsgc_merge u_merge (.clk(clk), .ctl(ctl), .spikes(spikes), .tick(mtick),
                      .fired(fired), .peak(peak));

  always_comb begin
    ctl.gate_b = gb;
    ctl.leak = gb ? b_leak : a_leak;
    ctl.thr = gb ? b_thr : a_thr;
    ctl.start = (state == ST_RUN) && (cnt == '0);
    tick = (state == ST_RUN) && (cnt >= 1) && (cnt <= NUM_STEPS);
    mtick = (state == ST_RUN) && (cnt >= 2) && (cnt <= NUM_STEPS + 1);
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_DONE);
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_RUN;
      ST_RUN:  if (cnt == (STEP_W+1)'(NUM_STEPS + 1)) state_next = ST_DONE;
      ST_DONE: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end
  // pre holds the step counter at zero after accept, so lane start repeats on settled norms
  logic pre;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; cnt <= '0; pre <= 1'b0;
    end else begin
      if (state == ST_IDLE && s_tvalid) pre <= 1'b1;
      else if (pre) pre <= 1'b0;
      if (state == ST_RUN && !pre) cnt <= cnt + 1'b1;
      else if (state != ST_RUN) cnt <= '0;
      state <= state_next;
    end
  end

  always_comb begin
    dom_next = 3'd0;
    best = nmask[0];
    for (int i = 1; i < MAX_FEATURES; i++) begin
      if ((gb || i < 4) && nmask[i] > best) begin
        best = nmask[i];
        dom_next = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dom <= dom_next;
    end
  end

  assign m_tdata = {feat[dom], dom, peak, fired};

  `LSGC_ASSERT_IMPL(a_excl, clk, rst, m_tvalid, !s_tready)
  `LSGC_ASSERT_IMPL(a_dom, clk, rst, m_tvalid, dom <= 3'd4)
  `LSGC_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the spiking gate classifier. It drives feature
// vectors on the input stream and changes the leak and threshold registers
// between phases. A scoreboard predicts each result and compares it with the
// output stream. Both stream sides idle at random, except in the burst phase.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import lsgc_pkg::*;

  typedef struct {
    bit        fired;
    bit [19:0] peak;
    bit [2:0]  index;
    bit [23:0] value;
  } gate_result_t;

  class gate_scoreboard;
    bit [15:0] leak_a = 16'd58982;
    bit [15:0] thr_a  = 16'd4096;
    bit [15:0] leak_b = 16'd58982;
    bit [15:0] thr_b  = 16'd4096;
    gate_result_t pending[$];
    int errors = 0;

    function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function longint weight(bit gb, int r, int i);
      int ta [12][4] = '{'{3277,4096,5734,7373},'{3621,3908,6479,6213},
        '{3649,3516,5114,6018},'{3335,3281,5505,7340},'{2967,3419,6545,6434},
        '{2884,3803,5289,5866},'{3163,4080,5295,7245},'{3546,3995,6546,6665},
        '{3682,3627,5498,5769},'{3446,3313,5119,7095},'{3054,3343,6482,6888},
        '{2867,3688,5727,5734}};
      int tb [12][5] = '{'{5325,6349,3277,4096,4915},'{5842,6066,3621,3908,5474},
        '{5883,5479,3649,3516,4450},'{5412,5126,3335,3281,4744},
        '{4860,5333,2967,3419,5523},'{4736,5908,2884,3803,4581},
        '{5153,6324,3163,4080,4585},'{5728,6198,3546,3995,5524},
        '{5933,5645,3682,3627,4738},'{5578,5174,3446,3313,4454},
        '{4991,5219,3054,3343,5476},'{4710,5737,2867,3688,4910}};
      return gb ? tb[r][i] : ta[r][i];
    endfunction

    function longint membrane(longint m, longint lk, longint c);
      return clip(((m * lk) >>> 16) + c, -1048576, 1048575);
    endfunction

    function gate_result_t classify(bit gb, bit [119:0] f);
      longint sa [4] = '{100, 60, 30, 40};
      longint sb [5] = '{5, 3, 10, 4, 500};
      longint raw [5];
      longint norm [5];
      longint cur1 [12];
      longint mem1 [12];
      longint v, acc, cur2, mem2, peak, best, lk, thr, b1, w2, b2;
      int nf, dom;
      bit fired;
      gate_result_t r;
      nf = gb ? 5 : 4;
      lk = gb ? leak_b : leak_a;
      thr = gb ? thr_b : thr_a;
      b1 = gb ? -2048 : -1638;
      w2 = gb ? 2253 : 2458;
      b2 = gb ? -1024 : -819;
      best = -1;
      dom = 0;
      for (int i = 0; i < 5; i++) begin
        raw[i] = 0;
        norm[i] = 0;
      end
      for (int i = 0; i < nf; i++) begin
        v = longint'($signed(f[24*i +: 24]));
        raw[i] = v;
        if (v < 0) v = 0;
        norm[i] = (v * 16) / (gb ? sb[i] : sa[i]);
        if (norm[i] > 12288) norm[i] = 12288;
        if (norm[i] > best) begin
          best = norm[i];
          dom = i;
        end
      end
      for (int h = 0; h < 12; h++) begin
        acc = b1 * 4096;
        for (int i = 0; i < nf; i++) acc += weight(gb, h % 12, i) * norm[i];
        cur1[h] = clip(acc >>> 12, -32768, 32767);
        mem1[h] = 0;
      end
      mem2 = 0;
      peak = 0;
      fired = 0;
      for (int t = 0; t < NUM_STEPS; t++) begin
        cur2 = b2;
        for (int h = 0; h < 12; h++) begin
          mem1[h] = membrane(mem1[h], lk, cur1[h]);
          if (mem1[h] >= thr) begin
            mem1[h] -= thr;
            cur2 += w2;
          end
        end
        mem2 = membrane(mem2, lk, clip(cur2, -32768, 32767));
        if (mem2 > peak) peak = mem2;
        if (mem2 >= thr) begin
          fired = 1;
          mem2 -= thr;
        end
      end
      r.fired = fired;
      r.peak = peak[19:0];
      r.index = dom[2:0];
      r.value = raw[dom][23:0];
      return r;
    endfunction

    function void note_input(bit gb, bit [119:0] f);
      pending.push_back(classify(gb, f));
    endfunction

    function void check_result(bit [47:0] d);
      gate_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e.fired) begin
        $display("%0t: fired exp %0d act %0d", $time, e.fired, d[0]);
        errors++;
      end
      if (d[20:1] !== e.peak) begin
        $display("%0t: peak exp %0d act %0d", $time, e.peak, d[20:1]);
        errors++;
      end
      if (d[23:21] !== e.index) begin
        $display("%0t: index exp %0d act %0d", $time, e.index, d[23:21]);
        errors++;
      end
      if (d[47:24] !== e.value) begin
        $display("%0t: value exp %h act %h", $time, e.value, d[47:24]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         psel = 0;
  logic         penable = 0;
  logic         pwrite = 0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  wire  [31:0]  prdata;
  wire          pready;
  logic         s_tvalid = 0;
  wire          s_tready;
  logic [119:0] s_tdata = '0;
  logic         s_tuser = 0;
  wire          m_tvalid;
  logic         m_tready = 0;
  wire  [47:0]  m_tdata;

  bit burst = 0;
  int quiet = 0;
  gate_scoreboard board = new();

  lif_spiking_gate_classifier DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      m_tready <= burst || ($urandom_range(99) >= 37);
      if (s_tvalid && s_tready) board.note_input(s_tuser, s_tdata);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 5000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 4'(idx * 4);
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      ADDR_A_LEAK: board.leak_a = val;
      ADDR_A_THR:  board.thr_a = val;
      ADDR_B_LEAK: board.leak_b = val;
      default:     board.thr_b = val;
    endcase
  endtask

  task automatic send(bit gb, bit [119:0] f);
    if (!burst && $urandom_range(99) < 37) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    s_tvalid <= 1;
    s_tuser <= gb;
    s_tdata <= f;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic bit [23:0] pick_feature(int scale);
    case ($urandom_range(7))
      0: return 24'($urandom);
      1: return -24'($urandom_range(1, 100000));
      default: return 24'($urandom_range(0, scale * 1024));
    endcase
  endfunction

  function automatic bit [119:0] pick_vector(bit gb);
    int sa [5] = '{100, 60, 30, 40, 500};
    int sb [5] = '{5, 3, 10, 4, 500};
    bit [119:0] f;
    for (int i = 0; i < 5; i++) f[24*i +: 24] = pick_feature(gb ? sb[i] : sa[i]);
    return f;
  endfunction

  initial begin
    bit [15:0] cfg [6][4];
    cfg[1] = '{16'd0, 16'd1, 16'd65535, 16'd65535};
    cfg[2] = '{16'd65535, 16'd65535, 16'd0, 16'd1};
    cfg[3] = '{16'd65535, 16'd0, 16'd30000, 16'd0};
    cfg[4] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    cfg[5] = '{16'd58982, 16'd4096, 16'd58982, 16'd4096};
    repeat (5) @(posedge clk);
    rst <= 0;
    for (int g = 0; g < 2; g++) begin
      send(g, '0);
      send(g, {5{24'h7FFFFF}});
      send(g, {5{24'h800000}});
      send(g, {5{24'hFFFFFF}});
      send(g, {5{24'h000100}});
      send(g, {24'h7FFFFF, 24'h800000, 24'h000001, 24'h7FFFFF, 24'h000500});
      for (int i = 0; i < 5; i++) send(g, 120'h7FFFFF << (24 * i));
    end
    send(0, {24'h7FFFFF, 96'd0});
    send(0, {24'h7FFFFF, 24'h000010, 24'h000010, 24'h000010, 24'h000010});
    drain();
    for (int p = 1; p < 6; p++) begin
      for (int r = 0; r < 4; r++) reg_write(3'(r), cfg[p][r]);
      burst = (p == 4);
      for (int n = 0; n < 170; n++) begin
        bit gb;
        gb = $urandom_range(1);
        send(gb, pick_vector(gb));
      end
      drain();
    end
    if (board.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/lsgc_pkg.sv
hw/rtl/lsgc_norm.sv
hw/rtl/lsgc_lane.sv
hw/rtl/lsgc_merge.sv
hw/rtl/lif_spiking_gate_classifier.sv
tb/testbench.sv
